FILE: hw/rtl/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared widths, constants and controller/datapath interface types for the
// prime factor counter.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int VALUE_W = 32;
  localparam int DIV_W   = VALUE_W / 2 + 1;
  localparam int COUNT_W = 6;
  localparam int STEP_W  = $clog2(VALUE_W);

  localparam logic [DIV_W-1:0]  FIRST_DIVISOR = DIV_W'(2);
  localparam logic [STEP_W-1:0] LAST_STEP     = STEP_W'(VALUE_W - 1);

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic count_prime;
    logic divide_out;
    logic next_divisor;
    logic emit;
  } pfc_cmd_t;

  typedef struct packed {
    logic below_two;
    logic div_done;
    logic over_root;
    logic exact;
  } pfc_status_t;

endpackage

FILE: hw/rtl/pfc_dpath.sv
// ----------------------------------------------------------------------------
// pfc_dpath
// Remainder, trial divisor and count registers with a restoring bit-serial
// divider that yields one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfc_dpath (
  input  logic                          clk,
  input  logic [pfc_pkg::VALUE_W-1:0]   value,
  input  pfc_pkg::pfc_cmd_t             cmd,
  output pfc_pkg::pfc_status_t          status,
  output logic [pfc_pkg::COUNT_W-1:0]   factor_count
);

  logic [pfc_pkg::VALUE_W-1:0] remaining;
  logic [pfc_pkg::DIV_W-1:0]   divisor;
  logic [pfc_pkg::COUNT_W-1:0] count;
  logic [pfc_pkg::VALUE_W-1:0] quot;
  logic [pfc_pkg::DIV_W-1:0]   prem;
  logic [pfc_pkg::STEP_W-1:0]  step;

  logic [pfc_pkg::DIV_W:0]     trial;
  logic                        trial_fits;
  logic [pfc_pkg::DIV_W:0]     trial_diff;

  assign trial      = {prem, quot[pfc_pkg::VALUE_W-1]};
  assign trial_fits = trial >= {1'b0, divisor};
  assign trial_diff = trial - {1'b0, divisor};

  assign status.below_two = remaining[pfc_pkg::VALUE_W-1:1] == '0;
  assign status.div_done  = step == pfc_pkg::LAST_STEP;
  assign status.over_root = pfc_pkg::VALUE_W'(divisor) > quot;
  assign status.exact     = prem == '0;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      remaining <= value;
      divisor   <= pfc_pkg::FIRST_DIVISOR;
      count     <= '0;
    end
    if (cmd.div_init) begin
      quot <= remaining;
      prem <= '0;
      step <= '0;
    end
    if (cmd.div_step) begin
      if (trial_fits) begin
        prem <= trial_diff[pfc_pkg::DIV_W-1:0];
      end else begin
        prem <= trial[pfc_pkg::DIV_W-1:0];
      end
      quot <= {quot[pfc_pkg::VALUE_W-2:0], trial_fits};
      step <= step + 1'b1;
    end
    if (cmd.count_prime) begin
      count <= count + 1'b1;
    end
    if (cmd.divide_out) begin
      remaining <= quot;
      count     <= count + 1'b1;
    end
    if (cmd.next_divisor) begin
      divisor <= divisor + 1'b1;
    end
    if (cmd.emit) begin
      factor_count <= count;
    end
  end

endmodule

FILE: hw/rtl/pfc_ctrl.sv
// ----------------------------------------------------------------------------
// pfc_ctrl
// Sequencer for the trial division: check the remainder, run one bit-serial
// division per trial, act on quotient and remainder, hand off result.
// ----------------------------------------------------------------------------
module pfc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  pfc_pkg::pfc_status_t status,
  output pfc_pkg::pfc_cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    CHECK,
    DIVIDE,
    DECIDE,
    FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = state != IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = CHECK;
        end
      end
      CHECK: begin
        if (status.below_two) begin
          state_next = FINISH;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = DIVIDE;
        end
      end
      DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = DECIDE;
        end
      end
      DECIDE: begin
        priority if (status.over_root) begin
          cmd.count_prime = 1'b1;
          state_next      = FINISH;
        end else if (status.exact) begin
          cmd.divide_out = 1'b1;
          state_next     = CHECK;
        end else begin
          cmd.next_divisor = 1'b1;
          state_next       = CHECK;
        end
      end
      FINISH: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/prime_factor_count.sv
// ----------------------------------------------------------------------------
// prime_factor_count
// Counts the prime factors of a 32-bit unsigned value, with multiplicity,
// by trial division.
// ----------------------------------------------------------------------------
// One request at a time. Each trial divisor takes a remainder check, a
// 32-bit division on the shared bit-serial divider and a decision; a
// factor found repeats the same divisor. Divisors run from 2 until their
// square exceeds the remainder, so inputs 0 and 1 finish without any
// division, while a large prime tries divisors up to about 65536. The result
// sits in an output register, and a new request is taken once the previous
// one has reached it.
// ----------------------------------------------------------------------------
module prime_factor_count (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pfc_pkg::VALUE_W-1:0] value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pfc_pkg::COUNT_W-1:0] factor_count
);

  pfc_pkg::pfc_cmd_t    cmd;
  pfc_pkg::pfc_status_t status;

  pfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pfc_dpath u_dpath (
    .clk          (clk),
    .value        (value),
    .cmd          (cmd),
    .status       (status),
    .factor_count (factor_count)
  );

endmodule
